[hw/rtl/ipvf_pkg.sv]
package ipvf_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam logic [1:0] CMD_FRAME  = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic RK_VERDICT = 1'b0;
    localparam logic RK_STATUS  = 1'b1;

    localparam logic VERDICT_PASS = 1'b0;
    localparam logic VERDICT_DROP = 1'b1;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam logic [5:0] MIN_FRAME_LEN = 6'd42;
    localparam logic [5:0] OFS_ETH_HI    = 6'd12;
    localparam logic [5:0] OFS_ETH_LO    = 6'd13;
    localparam logic [5:0] OFS_PROTO     = 6'd23;
    localparam logic [5:0] OFS_SRC_FIRST = 6'd26;
    localparam logic [5:0] OFS_SRC_LAST  = 6'd29;
    localparam logic [5:0] OFS_PORT_HI   = 6'd36;
    localparam logic [5:0] OFS_PORT_LO   = 6'd37;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic        found;
        logic [15:0] found_port;
        logic        free_found;
    } token_t;

    typedef struct packed {
        logic        en;
        logic        set;
        logic [31:0] key;
        logic [15:0] port;
    } update_t;

endpackage

[hw/rtl/ipvf_cell.sv]
module ipvf_cell #(
    parameter int IW    = 10,
    parameter int INDEX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ipvf_pkg::token_t  tok_in,
    input  logic [IW-1:0]     found_idx_in,
    input  logic [IW-1:0]     free_idx_in,
    output ipvf_pkg::token_t  tok_out,
    output logic [IW-1:0]     found_idx_out,
    output logic [IW-1:0]     free_idx_out,
    input  ipvf_pkg::update_t upd,
    input  logic [IW-1:0]     upd_idx
);
    import ipvf_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [31:0]   key_reg;
    logic [15:0]   port_reg;
    logic          used_reg;
    token_t        tok_reg;
    logic [IW-1:0] found_idx_reg;
    logic [IW-1:0] free_idx_reg;
    logic          hit;

    assign hit = tok_in.valid && used_reg && (key_reg == tok_in.key);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            if (upd.en && upd_idx == MY_IDX) begin
                used_reg <= upd.set;
            end
            tok_reg.valid <= tok_in.valid;
        end
        if (upd.en && upd.set && upd_idx == MY_IDX) begin
            key_reg  <= upd.key;
            port_reg <= upd.port;
        end
        tok_reg.key        <= tok_in.key;
        tok_reg.found      <= tok_in.found || hit;
        tok_reg.found_port <= hit ? port_reg : tok_in.found_port;
        found_idx_reg      <= hit ? MY_IDX : found_idx_in;
        tok_reg.free_found <= tok_in.free_found || !used_reg;
        free_idx_reg       <= tok_in.free_found ? free_idx_in : MY_IDX;
    end

    assign tok_out       = tok_reg;
    assign found_idx_out = found_idx_reg;
    assign free_idx_out  = free_idx_reg;

endmodule

[hw/rtl/ipv4_udp_source_port_filter.sv]
// Channel | Beat moves                                   | Handshake
// s_      | cmd, frame_byte, frame_last, address, port   | s_valid / s_ready
// m_      | result_kind, drop, status                    | m_valid / m_ready
//
// Frame bytes other than the last are accepted without a search.
// Last bytes and table commands send a search token down the row of
// TABLE_ENTRIES cells; the result is registered before the output register.
// One table item is in flight at a time; s_ready is low while it searches
// and until its result has moved into the output register.
// Reset clears the table valid bits and frame capture.
// A stalled result holds in the output register until taken.
module ipv4_udp_source_port_filter #(
    parameter int TABLE_ENTRIES = ipvf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_frame_byte,
    input  logic        s_frame_last,
    input  logic [31:0] s_entry_address,
    input  logic [15:0] s_entry_port,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic        m_drop,
    output logic [1:0]  m_status
);
    import ipvf_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [1:0] {IDLE, SEARCH, HOLD} state_t;

    state_t      state_reg;
    logic [7:0]  block_protocol_reg;
    logic [5:0]  byte_offset_reg;
    logic [15:0] ether_kind_reg;
    logic [7:0]  ip_protocol_reg;
    logic [31:0] source_address_reg;
    logic [15:0] dest_port_reg;
    logic [1:0]  pend_cmd_reg;
    logic        pend_ok_reg;
    logic [31:0] pend_key_reg;
    logic [15:0] pend_port_reg;
    logic        res_kind_reg;
    logic        res_drop_reg;
    logic [1:0]  res_status_reg;
    logic        m_valid_reg;
    logic        m_kind_reg;
    logic        m_drop_reg;
    logic [1:0]  m_status_reg;

    token_t        tok [TABLE_ENTRIES+1];
    logic [IW-1:0] fidx [TABLE_ENTRIES+1];
    logic [IW-1:0] eidx [TABLE_ENTRIES+1];
    update_t       upd;
    logic [IW-1:0] upd_idx;

    logic       accept;
    logic       launch;
    logic       is_frame;
    logic       frame_ok;
    logic       exit_valid;
    logic       ex_drop;
    logic [1:0] ex_status;

    assign s_ready  = (state_reg == IDLE);
    assign accept   = s_valid && s_ready;
    assign is_frame = (s_cmd == CMD_FRAME);
    assign launch   = accept && ((is_frame && s_frame_last) || s_cmd == CMD_WRITE
                                 || s_cmd == CMD_REMOVE);
    assign frame_ok = (byte_offset_reg >= MIN_FRAME_LEN - 6'd1)
                      && (ether_kind_reg == ETHERTYPE_IPV4)
                      && (ip_protocol_reg == block_protocol_reg)
                      && (ip_protocol_reg == PROTO_UDP);

    always_comb begin
        tok[0].valid      = launch;
        tok[0].key        = is_frame ? source_address_reg : s_entry_address;
        tok[0].found      = 1'b0;
        tok[0].found_port = '0;
        tok[0].free_found = 1'b0;
        fidx[0]           = '0;
        eidx[0]           = '0;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        ipvf_cell #(.IW(IW), .INDEX(i)) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .tok_in        (tok[i]),
            .found_idx_in  (fidx[i]),
            .free_idx_in   (eidx[i]),
            .tok_out       (tok[i+1]),
            .found_idx_out (fidx[i+1]),
            .free_idx_out  (eidx[i+1]),
            .upd           (upd),
            .upd_idx       (upd_idx)
        );
    end

    assign exit_valid = (state_reg == SEARCH) && tok[TABLE_ENTRIES].valid;

    always_comb begin
        upd.en    = 1'b0;
        upd.set   = 1'b0;
        upd.key   = pend_key_reg;
        upd.port  = pend_port_reg;
        upd_idx   = fidx[TABLE_ENTRIES];
        ex_drop   = VERDICT_PASS;
        ex_status = ST_DONE;
        case (pend_cmd_reg)
            CMD_FRAME: begin
                if (pend_ok_reg && tok[TABLE_ENTRIES].found
                    && tok[TABLE_ENTRIES].found_port == pend_port_reg) begin
                    ex_drop = VERDICT_DROP;
                end
            end
            CMD_WRITE: begin
                if (tok[TABLE_ENTRIES].found) begin
                    upd.en  = exit_valid;
                    upd.set = 1'b1;
                end else if (tok[TABLE_ENTRIES].free_found) begin
                    upd.en  = exit_valid;
                    upd.set = 1'b1;
                    upd_idx = eidx[TABLE_ENTRIES];
                end else begin
                    ex_status = ST_FULL;
                end
            end
            CMD_REMOVE: begin
                if (tok[TABLE_ENTRIES].found) begin
                    upd.en = exit_valid;
                end else begin
                    ex_status = ST_NOT_FOUND;
                end
            end
            default: begin
                ex_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= IDLE;
            block_protocol_reg <= '0;
            byte_offset_reg    <= '0;
            ether_kind_reg     <= '0;
            ip_protocol_reg    <= '0;
            source_address_reg <= '0;
            dest_port_reg      <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                block_protocol_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && state_reg != HOLD) begin
                m_valid_reg <= 1'b0;
            end
            if (accept && is_frame) begin
                if (s_frame_last) begin
                    byte_offset_reg    <= '0;
                    ether_kind_reg     <= '0;
                    ip_protocol_reg    <= '0;
                    source_address_reg <= '0;
                    dest_port_reg      <= '0;
                end else begin
                    if (byte_offset_reg < MIN_FRAME_LEN) begin
                        byte_offset_reg <= byte_offset_reg + 6'd1;
                    end
                    if (byte_offset_reg == OFS_ETH_HI || byte_offset_reg == OFS_ETH_LO) begin
                        ether_kind_reg <= {ether_kind_reg[7:0], s_frame_byte};
                    end
                    if (byte_offset_reg == OFS_PROTO) begin
                        ip_protocol_reg <= s_frame_byte;
                    end
                    if (byte_offset_reg >= OFS_SRC_FIRST && byte_offset_reg <= OFS_SRC_LAST) begin
                        source_address_reg <= {source_address_reg[23:0], s_frame_byte};
                    end
                    if (byte_offset_reg == OFS_PORT_HI || byte_offset_reg == OFS_PORT_LO) begin
                        dest_port_reg <= {dest_port_reg[7:0], s_frame_byte};
                    end
                end
            end
            case (state_reg)
                IDLE: begin
                    if (launch) begin
                        state_reg <= SEARCH;
                    end
                end
                SEARCH: begin
                    if (exit_valid) begin
                        state_reg <= HOLD;
                    end
                end
                HOLD: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
        if (launch) begin
            pend_cmd_reg  <= s_cmd;
            pend_ok_reg   <= frame_ok;
            pend_key_reg  <= s_entry_address;
            pend_port_reg <= is_frame ? dest_port_reg : s_entry_port;
        end
        if (exit_valid) begin
            res_kind_reg   <= (pend_cmd_reg == CMD_FRAME) ? RK_VERDICT : RK_STATUS;
            res_drop_reg   <= ex_drop;
            res_status_reg <= ex_status;
        end
        if (state_reg == HOLD && (!m_valid_reg || m_ready)) begin
            m_kind_reg   <= res_kind_reg;
            m_drop_reg   <= res_drop_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_drop        = m_drop_reg;
    assign m_status      = m_status_reg;

endmodule

[hw/rtl/ipvf_checker.sv]
module ipvf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_result_kind,
    input logic       m_drop,
    input logic [1:0] m_status
);
    import ipvf_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drop) && $stable(m_status))
        else $error("result beat changed while stalled");

    a_verdict_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == RK_VERDICT |-> m_status == ST_DONE)
        else $error("verdict carries a status");

    a_status_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == RK_STATUS |-> m_drop == VERDICT_PASS)
        else $error("status beat carries a drop");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == ST_DONE || m_status == ST_FULL || m_status == ST_NOT_FOUND)
        else $error("unknown status code");

endmodule

bind ipv4_udp_source_port_filter ipvf_checker u_ipvf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_kind (m_result_kind),
    .m_drop        (m_drop),
    .m_status      (m_status)
);

[bench/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ipvf_pkg::*;

    localparam int NSLOT = TABLE_ENTRIES_DEF;
    localparam int SEARCH_CYCLES = NSLOT + 2;
    localparam int IDLE_LIMIT = 4 * (SEARCH_CYCLES + 16) + 200;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  fbyte;
        logic        flast;
        logic [31:0] addr;
        logic [15:0] port;
    } beat_t;

    typedef struct {
        logic       kind;
        logic       drop;
        logic [1:0] status;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_cmd = '0;
    logic [7:0] s_frame_byte = '0;
    logic s_frame_last = 1'b0;
    logic [31:0] s_entry_address = '0;
    logic [15:0] s_entry_port = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_result_kind;
    logic m_drop;
    logic [1:0] m_status;

    ipv4_udp_source_port_filter u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_frame_byte(s_frame_byte), .s_frame_last(s_frame_last),
        .s_entry_address(s_entry_address), .s_entry_port(s_entry_port),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_kind(m_result_kind),
        .m_drop(m_drop), .m_status(m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // filter state mirror
    logic [7:0]  blk_proto;
    logic [5:0]  ofs;
    logic [15:0] eth_kind;
    logic [7:0]  ip_proto;
    logic [31:0] src_addr;
    logic [15:0] dst_port;
    logic [31:0] acl_key [NSLOT];
    logic [15:0] acl_port [NSLOT];
    bit          acl_used [NSLOT];

    beat_t    pending[$];
    verdict_t awaited[$];
    int fails = 0;
    int n_beats = 0, n_results = 0, n_drops = 0, n_full = 0, n_miss = 0;
    int idle_cycles = 0;
    bit stim_done = 0;

    // keys drawn for frames and table commands
    logic [31:0] key_pool[$];

    function automatic int find_slot(logic [31:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (acl_used[i] && acl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void clear_capture();
        ofs = '0; eth_kind = '0; ip_proto = '0; src_addr = '0; dst_port = '0;
    endfunction

    function automatic void predict_filter(beat_t b);
        verdict_t v;
        int slot;
        v = '{kind: RK_STATUS, drop: VERDICT_PASS, status: ST_DONE};
        if (b.cmd == CMD_FRAME) begin
            case (ofs)
                OFS_ETH_HI, OFS_ETH_LO: eth_kind = {eth_kind[7:0], b.fbyte};
                OFS_PROTO: ip_proto = b.fbyte;
                OFS_SRC_FIRST, 6'd27, 6'd28, OFS_SRC_LAST:
                    src_addr = {src_addr[23:0], b.fbyte};
                OFS_PORT_HI, OFS_PORT_LO: dst_port = {dst_port[7:0], b.fbyte};
                default: ;
            endcase
            if (ofs < MIN_FRAME_LEN) ofs++;
            if (!b.flast) return;
            v.kind = RK_VERDICT;
            if (ofs >= MIN_FRAME_LEN && eth_kind == ETHERTYPE_IPV4) begin
                slot = find_slot(src_addr);
                if (slot >= 0 && ip_proto == blk_proto && ip_proto == PROTO_UDP &&
                    dst_port == acl_port[slot])
                    v.drop = VERDICT_DROP;
            end
            clear_capture();
        end else if (b.cmd == CMD_WRITE) begin
            slot = find_slot(b.addr);
            if (slot < 0)
                for (int i = 0; i < NSLOT; i++)
                    if (!acl_used[i]) begin
                        slot = i;
                        break;
                    end
            if (slot < 0) v.status = ST_FULL;
            else begin
                acl_key[slot] = b.addr;
                acl_port[slot] = b.port;
                acl_used[slot] = 1;
            end
        end else if (b.cmd == CMD_REMOVE) begin
            slot = find_slot(b.addr);
            if (slot < 0) v.status = ST_NOT_FOUND;
            else acl_used[slot] = 0;
        end else return;
        awaited.push_back(v);
    endfunction

    // handshakes seen at the last rising edge
    bit in_acc = 1'b0;
    bit out_acc = 1'b0;
    always @(posedge aclk) begin
        in_acc <= aresetn && s_valid && s_ready;
        out_acc <= aresetn && m_valid && m_ready;
    end

    // driver
    int src_wait = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_acc) begin
                predict_filter(pending.pop_front());
                n_beats++;
                src_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 3) == 0) src_wait = 0;
            end
            if (s_valid && !in_acc) begin
                // hold
            end else if (pending.size() > 0 && src_wait == 0) begin
                s_valid <= 1'b1;
                s_cmd <= pending[0].cmd;
                s_frame_byte <= pending[0].fbyte;
                s_frame_last <= pending[0].flast;
                s_entry_address <= pending[0].addr;
                s_entry_port <= pending[0].port;
            end else begin
                s_valid <= 1'b0;
                if (src_wait > 0) src_wait--;
            end
        end
    end

    // monitor
    int sink_wait = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (awaited.size() == 0) begin
                    $error("result with nothing awaited: kind %0d drop %0d status %0d",
                           m_result_kind, m_drop, m_status);
                    fails++;
                end else begin
                    verdict_t e;
                    e = awaited.pop_front();
                    if (m_result_kind !== e.kind) begin
                        $error("result_kind expected %0d got %0d", e.kind, m_result_kind);
                        fails++;
                    end
                    if (m_drop !== e.drop) begin
                        $error("drop expected %0d got %0d", e.drop, m_drop);
                        fails++;
                    end
                    if (m_status !== e.status) begin
                        $error("status expected %0d got %0d", e.status, m_status);
                        fails++;
                    end
                    if (e.kind == RK_VERDICT && e.drop) n_drops++;
                    if (e.status == ST_FULL) n_full++;
                    if (e.status == ST_NOT_FOUND) n_miss++;
                end
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        if (out_acc) sink_wait = $urandom_range(0, 14);
        if (sink_wait > 0 && $urandom_range(0, 2) != 0) begin
            m_ready <= 1'b0;
            sink_wait--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 4) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom();
    endfunction

    function automatic void add_table(logic [1:0] c, logic [31:0] k, logic [15:0] p);
        pending.push_back('{cmd: c, fbyte: 8'($urandom()), flast: 1'($urandom()), addr: k,
                            port: p});
    endfunction

    // build one frame; len bytes, header fields placed at their offsets, stray unused commands mixed in
    function automatic void add_frame(int len, logic [15:0] et, logic [7:0] pr,
                                      logic [31:0] src, logic [15:0] dp);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom());
            case (i)
                12: b = et[15:8];
                13: b = et[7:0];
                23: b = pr;
                26: b = src[31:24];
                27: b = src[23:16];
                28: b = src[15:8];
                29: b = src[7:0];
                36: b = dp[15:8];
                37: b = dp[7:0];
                default: ;
            endcase
            pending.push_back('{cmd: CMD_FRAME, fbyte: b, flast: i == len - 1,
                                addr: $urandom(), port: 16'($urandom())});
            if ($urandom_range(0, 30) == 0)
                add_table(CMD_UNUSED, $urandom(), 16'($urandom()));
        end
    endfunction

    task automatic drain_and_config(logic [7:0] proto);
        wait (pending.size() == 0 && !s_valid);
        wait (awaited.size() == 0);
        repeat (SEARCH_CYCLES + 20) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= proto;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        blk_proto = proto;
    endtask

    initial begin
        logic [31:0] k;
        logic [15:0] p;
        int slot;
        blk_proto = '0;
        clear_capture();
        for (int i = 0; i < NSLOT; i++) begin
            acl_used[i] = 0; acl_key[i] = '0; acl_port[i] = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        drain_and_config(PROTO_UDP);
        // directed: table edge cases and frame extremes
        add_table(CMD_WRITE, 32'hFFFF_FFFF, 16'hFFFF);
        add_table(CMD_WRITE, 32'h0000_0000, 16'h0000);
        add_table(CMD_WRITE, 32'hFFFF_FFFF, 16'h1234);
        add_table(CMD_REMOVE, 32'hDEAD_BEEF, 16'h0);
        add_table(CMD_WRITE, 32'hC0A8_0001, 16'd53);
        add_table(CMD_UNUSED, 32'hC0A8_0001, 16'd53);
        add_frame(42, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 16'd53);
        add_frame(60, ETHERTYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFF, 16'h1234);
        add_frame(41, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 16'd53);
        add_frame(1, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0);
        add_frame(64, 16'h86DD, PROTO_UDP, 32'h0, 16'h0);
        add_frame(42, ETHERTYPE_IPV4, 8'd6, 32'hC0A8_0001, 16'd53);
        add_frame(42, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 16'd54);
        add_table(CMD_REMOVE, 32'hC0A8_0001, 16'h0);
        add_frame(42, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 16'd53);
        add_table(CMD_REMOVE, 32'hC0A8_0001, 16'h0);
        key_pool = '{32'hFFFF_FFFF, 32'h0, 32'hC0A8_0001};

        // protocol matches the register but is not UDP
        drain_and_config(8'd0);
        add_frame(42, ETHERTYPE_IPV4, 8'd0, 32'h0, 16'h0);

        // random phases over several protocol settings
        for (int ph = 0; ph < 3; ph++) begin
            drain_and_config(ph == 1 ? 8'd255 : PROTO_UDP);
            for (int n = 0; n < 7; n++) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        k = $urandom();
                        key_pool.push_back(k);
                        add_table(CMD_WRITE, k, 16'($urandom()));
                    end
                    2: add_table(CMD_REMOVE, pick_key(), 16'($urandom()));
                    3: add_table($urandom_range(0, 1) ? CMD_WRITE : CMD_UNUSED,
                                 pick_key(), 16'($urandom()));
                    default: begin
                        k = pick_key();
                        slot = find_slot(k);
                        p = 16'($urandom());
                        if ($urandom_range(0, 3) != 0) begin
                            if (slot >= 0) p = acl_port[slot];
                            foreach (pending[i])
                                if (pending[i].cmd == CMD_WRITE && pending[i].addr == k)
                                    p = pending[i].port;
                        end
                        add_frame($urandom_range(0, 5) == 0 ? $urandom_range(1, 41)
                                                            : $urandom_range(42, 70),
                                  $urandom_range(0, 7) == 0 ? 16'($urandom())
                                                            : ETHERTYPE_IPV4,
                                  $urandom_range(0, 5) == 0 ? 8'($urandom())
                                                            : PROTO_UDP,
                                  k, p);
                    end
                endcase
                if (pending.size() > 400) wait (pending.size() < 100);
            end
        end
        drain_and_config(8'd0);
        wait (pending.size() == 0 && !s_valid);
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        wait (awaited.size() == 0);
        repeat (SEARCH_CYCLES + 20) @(posedge aclk);
        $display("covered %0d beats, %0d results: %0d drops, %0d table full, %0d absent",
                 n_beats, n_results, n_drops, n_full, n_miss);
        if (fails == 0 && awaited.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
